// File: src/kle_pkg.sv
// Shared types, codes and constants for the keyed line number extractor.
package kle_pkg;

	localparam int MAX_KEY_LEN = 16;
	localparam int KEY_LEN_W   = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [3:0] HEX_LETTER_BIAS = 4'd9;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_KEY_LEN  = 2'd2,
		REG_HEX_MODE = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NO_KEY    = 2'd1,
		ST_NO_DIGITS = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_COMPARE  = 3'd0,
		PH_SKIPLINE = 3'd1,
		PH_BLANKS   = 3'd2,
		PH_DIGITS   = 3'd3,
		PH_DONE     = 3'd4
	} phase_t;

	typedef struct packed {
		logic [MAX_KEY_LEN-1:0][7:0] key;
		logic [KEY_LEN_W-1:0]        key_len;
		logic                        hex_mode;
	} cfg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last;
		logic       zero;
		logic       newline;
		logic       blank;
		logic       digit;
		logic [3:0] digit_val;
	} item_t;

endpackage

// File: src/kle_front.sv
// Front end: accepts text bytes and classifies them for the parser.
module kle_front (
	input  logic          text_valid,
	output logic          text_ready,
	input  logic [7:0]    text_byte,
	input  logic          last_byte,
	input  logic          hex_mode,
	input  logic          queue_full,
	output logic          push,
	output kle_pkg::item_t item
);

	logic is_num;
	logic is_lower;
	logic is_upper;

	assign text_ready = !queue_full;
	assign push       = text_valid && text_ready;

	always_comb begin
		is_num   = (text_byte >= kle_pkg::CH_ZERO) && (text_byte <= kle_pkg::CH_NINE);
		is_lower = (text_byte >= kle_pkg::CH_LA) && (text_byte <= kle_pkg::CH_LF);
		is_upper = (text_byte >= kle_pkg::CH_UA) && (text_byte <= kle_pkg::CH_UF);

		item.text_byte = text_byte;
		item.last      = last_byte;
		item.zero      = (text_byte == 8'd0);
		item.newline   = (text_byte == kle_pkg::CH_NL);
		item.blank     = (text_byte == kle_pkg::CH_SPACE) || (text_byte == kle_pkg::CH_TAB);
		item.digit     = is_num || (hex_mode && (is_lower || is_upper));
		// letters a-f and A-F both carry 1..6 in the low nibble
		item.digit_val = is_num ? text_byte[3:0]
		                        : text_byte[3:0] + kle_pkg::HEX_LETTER_BIAS;
	end

endmodule

// File: src/kle_queue.sv
// Short FIFO of classified bytes between front end and parser.
module kle_queue #(
	parameter int DEPTH = kle_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  kle_pkg::item_t push_item,
	input  logic           pop,
	output kle_pkg::item_t head_item,
	output logic           not_empty,
	output logic           full,
	output logic [CNT_W-1:0] count
);

	kle_pkg::item_t   slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head_item = slots_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= advance(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= advance(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/kle_back.sv
// Parser back end: key match, blank skip, number accumulation, result register.
module kle_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kle_pkg::cfg_t        cfg,
	input  kle_pkg::item_t       item,
	input  logic                 item_valid,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [1:0]           status,
	output logic [63:0]          value
);

	localparam int KW = kle_pkg::KEY_LEN_W;

	kle_pkg::phase_t phase_q, ph, c_phase;
	logic [KW-1:0]   mp_q, c_mp, klen;
	logic [63:0]     acc_q, c_acc;
	logic            seen_q, c_seen, sat_q, c_sat;
	logic [67:0]     dec_sum;
	logic            give_num, give_end, result, number_path;
	kle_pkg::status_t res_status;
	logic [63:0]     res_value;

	logic            valid_q;
	logic [1:0]      status_q;
	logic [63:0]     value_q;

	assign pop          = item_valid && (!valid_q || result_ready);
	assign result_valid = valid_q;
	assign status       = status_q;
	assign value        = value_q;

	// next state
	always_comb begin
		klen = (cfg.key_len > KW'(kle_pkg::MAX_KEY_LEN)) ? KW'(kle_pkg::MAX_KEY_LEN)
		                                                 : cfg.key_len;
		dec_sum = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 68'(item.digit_val);
		ph       = phase_q;
		c_phase  = phase_q;
		c_mp     = mp_q;
		c_acc    = acc_q;
		c_seen   = seen_q;
		c_sat    = sat_q;
		give_num = 1'b0;
		if (!item.zero && phase_q != kle_pkg::PH_DONE) begin
			if (ph == kle_pkg::PH_COMPARE && mp_q >= klen) begin
				ph = kle_pkg::PH_BLANKS;
			end
			if (ph == kle_pkg::PH_COMPARE) begin
				if (item.text_byte == cfg.key[mp_q[3:0]]) begin
					c_mp    = mp_q + 1'b1;
					c_phase = (c_mp >= klen) ? kle_pkg::PH_BLANKS : kle_pkg::PH_COMPARE;
				end else begin
					c_mp    = '0;
					c_phase = item.newline ? kle_pkg::PH_COMPARE : kle_pkg::PH_SKIPLINE;
				end
			end else if (ph == kle_pkg::PH_SKIPLINE) begin
				if (item.newline) begin
					c_phase = kle_pkg::PH_COMPARE;
					c_mp    = '0;
				end
			end else if (ph == kle_pkg::PH_BLANKS && item.blank) begin
				c_phase = kle_pkg::PH_BLANKS;
			end else begin
				c_phase = kle_pkg::PH_DIGITS;
				if (!item.digit) begin
					give_num = 1'b1;
				end else begin
					c_seen = 1'b1;
					if (cfg.hex_mode) begin
						c_acc = {acc_q[59:0], item.digit_val};
					end else if (!sat_q) begin
						if (dec_sum[67:64] != 4'd0) begin
							c_sat = 1'b1;
							c_acc = '1;
						end else begin
							c_acc = dec_sum[63:0];
						end
					end
				end
			end
		end
		give_end = (phase_q != kle_pkg::PH_DONE) && !give_num && (item.zero || item.last);
		result   = give_num || give_end;
	end

	// result payload
	always_comb begin
		number_path = give_num || (give_end && (c_phase == kle_pkg::PH_BLANKS ||
		                                       c_phase == kle_pkg::PH_DIGITS));
		res_status = kle_pkg::ST_NO_KEY;
		res_value  = '0;
		if (number_path) begin
			if (cfg.hex_mode || (!c_sat && c_seen)) begin
				res_status = kle_pkg::ST_FOUND;
				res_value  = c_acc;
			end else if (c_sat) begin
				res_status = kle_pkg::ST_SATURATED;
				res_value  = '1;
			end else begin
				res_status = kle_pkg::ST_NO_DIGITS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kle_pkg::PH_COMPARE;
			mp_q    <= '0;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			sat_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (item.last) begin
					phase_q <= kle_pkg::PH_COMPARE;
					mp_q    <= '0;
					acc_q   <= '0;
					seen_q  <= 1'b0;
					sat_q   <= 1'b0;
				end else if (result) begin
					phase_q <= kle_pkg::PH_DONE;
				end else begin
					phase_q <= c_phase;
					mp_q    <= c_mp;
					acc_q   <= c_acc;
					seen_q  <= c_seen;
					sat_q   <= c_sat;
				end
			end
			if (pop && result) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && result) begin
			status_q <= res_status;
			value_q  <= res_value;
		end
	end

endmodule

// File: src/keyed_line_number_extractor.sv
// Top level of the keyed line number extractor: config registers and the front/queue/back chain.
//
// Usage: text bytes arrive on the text channel (text_valid/text_ready with text_byte and
// last_byte), one transfer per byte. At every line start the leading bytes are compared with
// the key held in the config registers; after the first matching line, blanks are skipped
// and a decimal or hex number is read. Each text yields exactly one result transfer on the
// result channel (result_valid/result_ready with status and value), issued at the first
// non-digit, at a zero byte or at the byte flagged last_byte.
// Throughput: one byte per cycle while no result waits on result_ready. A byte is written
// into the queue on its transfer; the parser takes it from the queue head and, when it ends a
// text's result, loads the output register that drives result_valid. The queue
// (QUEUE_DEPTH entries) lets the front keep taking bytes while a finished result waits.
// Stall: when result_ready is low with a result pending, the parser holds; the queue fills
// and text_ready drops once it is full.
// Config: cfg_write with cfg_index/cfg_data writes a register; write only while idle.
// Reset: arst_n clears the parser to line start and empties the queue and output register;
// key registers clear, key_length returns to 1 and hex_mode to decimal.
module keyed_line_number_extractor #(
	parameter int QUEUE_DEPTH = kle_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [kle_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [kle_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            text_valid,
	output logic                            text_ready,
	input  logic [7:0]                      text_byte,
	input  logic                            last_byte,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [1:0]                      status,
	output logic [63:0]                     value
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	kle_pkg::cfg_t  cfg_q;
	kle_pkg::item_t front_item, head_item;
	logic           push, pop, q_not_empty, q_full;
	logic [CNT_W-1:0] q_count;

	// Config registers: key characters in two halves, length and mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key      <= '0;
			cfg_q.key_len  <= kle_pkg::KEY_LEN_W'(1);
			cfg_q.hex_mode <= 1'b0;
		end else if (cfg_write) begin
			unique case (kle_pkg::cfg_reg_t'(cfg_index))
				kle_pkg::REG_KEY_LOW:  cfg_q.key[7:0]   <= cfg_data;
				kle_pkg::REG_KEY_HIGH: cfg_q.key[15:8]  <= cfg_data;
				kle_pkg::REG_KEY_LEN:  cfg_q.key_len    <= cfg_data[kle_pkg::KEY_LEN_W-1:0];
				kle_pkg::REG_HEX_MODE: cfg_q.hex_mode   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Classify each byte as it is taken.
	kle_front u_front (
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_byte  (text_byte),
		.last_byte  (last_byte),
		.hex_mode   (cfg_q.hex_mode),
		.queue_full (q_full),
		.push       (push),
		.item       (front_item)
	);

	// Decouple the front from the parser so either side can stall alone.
	kle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head_item (head_item),
		.not_empty (q_not_empty),
		.full      (q_full),
		.count     (q_count)
	);

	// Parse and hold the result until the receiver takes it.
	kle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item         (head_item),
		.item_valid   (q_not_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.value        (value)
	);

	// Queue never overflows its depth.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// Front stalls only because the queue is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!text_ready |-> q_count == CNT_W'(QUEUE_DEPTH))
		else $error("text_ready low with queue space");

	// Results without a number carry a zero value.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == kle_pkg::ST_NO_KEY || status == kle_pkg::ST_NO_DIGITS)
		|-> value == '0)
		else $error("nonzero value without a number");

	// Saturated decimal results read as all ones.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == kle_pkg::ST_SATURATED |-> value == '1)
		else $error("saturated value not all ones");

endmodule
